>>> design/vomf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vomf_pkg: shared types for the vehicle operational mode controller
// Mode, intent, opcode and error codes, and the request and response items.
// ----------------------------------------------------------------------------
package vomf_pkg;

   // Safety mode of the chassis
   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_ARMED   = 3'd1,
      MODE_MOVING  = 3'd2,
      MODE_DOCKING = 3'd3,
      MODE_FAULT   = 3'd4,
      MODE_ESTOP   = 3'd5
   } mode_type;

   // Locomotion intent
   typedef enum logic [1:0] {
      INTENT_NONE  = 2'd0,
      INTENT_STAND = 2'd1,
      INTENT_WALK  = 2'd2,
      INTENT_WHEEL = 2'd3
   } intent_type;

   // Event codes; 12..15 are unknown
   typedef enum logic [3:0] {
      OP_MOTION    = 4'd0,
      OP_FAULT     = 4'd1,
      OP_ESTOP     = 4'd2,
      OP_CLR_ESTOP = 4'd3,
      OP_CLR_FAULT = 4'd4,
      OP_ARM       = 4'd5,
      OP_DISARM    = 4'd6,
      OP_DOCK      = 4'd7,
      OP_UNDOCK    = 4'd8,
      OP_STAND     = 4'd9,
      OP_WALK      = 4'd10,
      OP_WHEEL     = 4'd11
   } opcode_type;

   // Rejection reasons
   typedef enum logic [2:0] {
      ERR_NONE          = 3'd0,
      ERR_NOT_ESTOP     = 3'd1,
      ERR_NOT_FAULT     = 3'd2,
      ERR_ARM_BLOCKED   = 3'd3,
      ERR_DISARM_BLOCKED = 3'd4,
      ERR_DOCK_BLOCKED  = 3'd5,
      ERR_NOT_DOCKING   = 3'd6,
      ERR_UNKNOWN       = 3'd7
   } error_type;

   typedef struct packed {
      opcode_type opcode;
      logic       twist_nonzero;
   } req_type;

   typedef struct packed {
      mode_type   mode_out;
      intent_type intent_out;
      logic       accepted;
      error_type  error_code;
      logic       motion_permitted;
   } rsp_type;

endpackage : vomf_pkg
`default_nettype wire

>>> design/vehicle_operational_mode_fsm_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vehicle_operational_mode_fsm_core: safety mode controller
//
// Takes one event item per cycle on the req_ channel (valid/ready) and
// returns exactly one result item per event on the rsp_ channel. The result
// carries the mode and intent after the event, the accept flag, the error
// code and whether the new mode permits motion.
// The result is valid in the cycle after accept. Throughput: one item per
// cycle; the mode update and the result are computed by single-level logic
// between the state/input and the one-deep result register.
// When the receiver stalls, the result register holds its item and
// req_ready drops only while that register is full and rsp_ready is low.
// csr_we writes idle_lock (bit 0 of csr_wdata) on the clock edge; write it
// only while no item is in flight.
// Reset (synchronous, active high): mode idle, intent none,
// idle_lock set, result register empty.
// ----------------------------------------------------------------------------
module vehicle_operational_mode_fsm_core
   import vomf_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data,
   input  wire logic    csr_we,
   input  wire logic    csr_wdata
);

   mode_type   mode_ff, mode_in;
   intent_type intent_ff, intent_in;
   error_type  err;
   logic       idle_lock_ff;
   logic       rsp_valid_ff;
   rsp_type    rsp_data_ff, rsp_data_in;
   logic       req_fire;
   logic       halted;

   // Accept while the result register is empty or being drained
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign halted    = (mode_ff == MODE_ESTOP) || (mode_ff == MODE_FAULT);

   // Next mode, intent and error for the offered event
   always_comb begin
      mode_in   = mode_ff;
      intent_in = intent_ff;
      err       = ERR_NONE;
      case (req_data.opcode)
         OP_MOTION: begin
            if (!halted) begin
               if (req_data.twist_nonzero) begin
                  if (mode_ff == MODE_ARMED || mode_ff == MODE_IDLE) mode_in = MODE_MOVING;
               end else if (mode_ff == MODE_MOVING) begin
                  mode_in = MODE_ARMED;
               end
            end
         end
         OP_FAULT: begin
            if (mode_ff != MODE_ESTOP) mode_in = MODE_FAULT;
         end
         OP_ESTOP: begin
            mode_in = MODE_ESTOP;
         end
         OP_CLR_ESTOP: begin
            if (mode_ff != MODE_ESTOP) err = ERR_NOT_ESTOP;
            else mode_in = MODE_IDLE;
         end
         OP_CLR_FAULT: begin
            if (mode_ff != MODE_FAULT) err = ERR_NOT_FAULT;
            else mode_in = MODE_IDLE;
         end
         OP_ARM: begin
            if (halted) err = ERR_ARM_BLOCKED;
            else mode_in = MODE_ARMED;
         end
         OP_DISARM: begin
            if (mode_ff == MODE_ESTOP) err = ERR_DISARM_BLOCKED;
            else mode_in = MODE_IDLE;
         end
         OP_DOCK: begin
            if (halted) err = ERR_DOCK_BLOCKED;
            else mode_in = MODE_DOCKING;
         end
         OP_UNDOCK: begin
            if (mode_ff != MODE_DOCKING) err = ERR_NOT_DOCKING;
            else mode_in = MODE_ARMED;
         end
         OP_STAND: begin
            intent_in = INTENT_STAND;
         end
         OP_WALK: begin
            intent_in = INTENT_WALK;
         end
         OP_WHEEL: begin
            intent_in = INTENT_WHEEL;
         end
         default: begin
            err = ERR_UNKNOWN;
         end
      endcase
   end

   // Build the result item from the post-event state
   always_comb begin
      rsp_data_in.mode_out   = mode_in;
      rsp_data_in.intent_out = intent_in;
      rsp_data_in.accepted   = (err == ERR_NONE);
      rsp_data_in.error_code = err;
      case (mode_in)
         MODE_ARMED, MODE_MOVING, MODE_DOCKING: rsp_data_in.motion_permitted = 1'b1;
         MODE_IDLE: rsp_data_in.motion_permitted = !idle_lock_ff;
         default:   rsp_data_in.motion_permitted = 1'b0;
      endcase
   end

   // Advance state on accept
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         intent_ff <= INTENT_NONE;
      end else if (req_fire) begin
         mode_ff   <= mode_in;
         intent_ff <= intent_in;
      end
   end

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         idle_lock_ff <= 1'b1;
      end else if (csr_we) begin
         idle_lock_ff <= csr_wdata;
      end
   end

   // Result register: load on accept, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule : vehicle_operational_mode_fsm_core
`default_nettype wire

>>> tb/sv/tb_vehicle_operational_mode_fsm_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vehicle_operational_mode_fsm_core: self-checking bench for the mode FSM
// Sends event items on the req_ channel, predicts each status item from an
// internal copy of mode, intent and idle_lock, and compares every status
// item on the rsp_ channel field by field. Both sides stall at random.
// ----------------------------------------------------------------------------
module tb_vehicle_operational_mode_fsm_core;
   import vomf_pkg::*;

   localparam int STALL_PCT     = 21;
   localparam int WATCHDOG_MAX  = 1000;
   localparam int REPORT_MAX    = 10;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_we = 1'b0;
   logic    csr_wdata = 1'b0;

   // Predicted controller state
   mode_type   model_mode = MODE_IDLE;
   intent_type model_intent = INTENT_NONE;
   logic       model_idle_lock = 1'b1;

   rsp_type expected_status_q[$];
   int      mismatch_count = 0;
   int      quiet_cycles = 0;
   bit      quiet_stretch = 1'b0;

   vehicle_operational_mode_fsm_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Apply one event to the predicted state and return the status it causes
   function automatic rsp_type next_status(input req_type ev);
      rsp_type   st;
      mode_type  m;
      logic      halted;
      error_type err;
      m      = model_mode;
      halted = (m == MODE_ESTOP) || (m == MODE_FAULT);
      err    = ERR_NONE;
      case (ev.opcode)
         OP_MOTION: begin
            if (!halted) begin
               if (ev.twist_nonzero) begin
                  if (m == MODE_ARMED || m == MODE_IDLE) model_mode = MODE_MOVING;
               end else if (m == MODE_MOVING) begin
                  model_mode = MODE_ARMED;
               end
            end
         end
         OP_FAULT: if (m != MODE_ESTOP) model_mode = MODE_FAULT;
         OP_ESTOP: model_mode = MODE_ESTOP;
         OP_CLR_ESTOP: begin
            if (m != MODE_ESTOP) err = ERR_NOT_ESTOP;
            else model_mode = MODE_IDLE;
         end
         OP_CLR_FAULT: begin
            if (m != MODE_FAULT) err = ERR_NOT_FAULT;
            else model_mode = MODE_IDLE;
         end
         OP_ARM: begin
            if (halted) err = ERR_ARM_BLOCKED;
            else model_mode = MODE_ARMED;
         end
         OP_DISARM: begin
            if (m == MODE_ESTOP) err = ERR_DISARM_BLOCKED;
            else model_mode = MODE_IDLE;
         end
         OP_DOCK: begin
            if (halted) err = ERR_DOCK_BLOCKED;
            else model_mode = MODE_DOCKING;
         end
         OP_UNDOCK: begin
            if (m != MODE_DOCKING) err = ERR_NOT_DOCKING;
            else model_mode = MODE_ARMED;
         end
         OP_STAND: model_intent = INTENT_STAND;
         OP_WALK:  model_intent = INTENT_WALK;
         OP_WHEEL: model_intent = INTENT_WHEEL;
         default:  err = ERR_UNKNOWN;
      endcase
      st.mode_out   = model_mode;
      st.intent_out = model_intent;
      st.accepted   = (err == ERR_NONE);
      st.error_code = err;
      case (model_mode)
         MODE_ARMED, MODE_MOVING, MODE_DOCKING: st.motion_permitted = 1'b1;
         MODE_IDLE: st.motion_permitted = !model_idle_lock;
         default:   st.motion_permitted = 1'b0;
      endcase
      return st;
   endfunction

   // Count a field mismatch and report the first few
   task automatic check_field(input string name, input logic [7:0] exp_v,
                              input logic [7:0] act_v);
      if (exp_v !== act_v) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_MAX)
            $display("%0t mismatch %s: expected %0d actual %0d", $realtime, name, exp_v,
                     act_v);
      end
   endtask

   // Check each status item against the oldest prediction
   always @(posedge clock) begin
      rsp_type exp_st;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_status_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("%0t unexpected status item %h", $realtime, rsp_data);
         end else begin
            exp_st = expected_status_q.pop_front();
            check_field("mode_out", 8'(exp_st.mode_out), 8'(rsp_data.mode_out));
            check_field("intent_out", 8'(exp_st.intent_out), 8'(rsp_data.intent_out));
            check_field("accepted", 8'(exp_st.accepted), 8'(rsp_data.accepted));
            check_field("error_code", 8'(exp_st.error_code), 8'(rsp_data.error_code));
            check_field("motion_permitted", 8'(exp_st.motion_permitted),
                        8'(rsp_data.motion_permitted));
         end
      end
   end

   // Stall the receiver at random, except during a quiet stretch
   always @(negedge clock) begin
      rsp_ready <= quiet_stretch || ($urandom_range(99) >= STALL_PCT);
   end

   // End the run when nothing moves for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_MAX) begin
         $display("[vehicle_operational_mode_fsm_core] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Send one event item; enter and leave at a falling edge
   task automatic send_event(input req_type ev);
      if (!quiet_stretch) begin
         while ($urandom_range(99) < STALL_PCT) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= ev;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_status_q.push_back(next_status(ev));
      @(negedge clock);
   endtask

   task automatic send_op(input opcode_type op, input logic twist);
      req_type ev;
      ev.opcode        = op;
      ev.twist_nonzero = twist;
      send_event(ev);
   endtask

   // Drop valid and wait until every predicted status item has arrived
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (expected_status_q.size() != 0) @(negedge clock);
      @(negedge clock);
   endtask

   // Write idle_lock while the block is idle
   task automatic write_idle_lock(input logic value);
      wait_for_results();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      model_idle_lock = value;
   endtask

   // Walk the mode graph through every guard, with idle_lock at reset value
   task automatic test_mode_commands();
      send_op(OP_MOTION, 1'b0);
      send_op(OP_MOTION, 1'b1);
      send_op(OP_MOTION, 1'b0);
      send_op(OP_MOTION, 1'b1);
      send_op(OP_DOCK, 1'b1);
      send_op(OP_MOTION, 1'b1);
      send_op(OP_UNDOCK, 1'b0);
      send_op(OP_UNDOCK, 1'b1);
      send_op(OP_CLR_ESTOP, 1'b0);
      send_op(OP_CLR_FAULT, 1'b1);
      send_op(OP_FAULT, 1'b0);
      send_op(OP_MOTION, 1'b1);
      send_op(OP_ARM, 1'b0);
      send_op(OP_DOCK, 1'b0);
      send_op(OP_CLR_FAULT, 1'b0);
      send_op(OP_FAULT, 1'b1);
      send_op(OP_DISARM, 1'b0);
      send_op(OP_ESTOP, 1'b0);
      send_op(OP_FAULT, 1'b0);
      send_op(OP_DISARM, 1'b1);
      send_op(OP_CLR_ESTOP, 1'b1);
      send_op(OP_ARM, 1'b1);
   endtask

   // Set each intent and hit unknown opcodes 12 and 15
   task automatic test_intent_and_unknown();
      send_op(OP_STAND, 1'b0);
      send_op(OP_WALK, 1'b1);
      send_op(OP_WHEEL, 1'b0);
      send_op(opcode_type'(4'd12), 1'b1);
      send_op(opcode_type'(4'd15), 1'b0);
   endtask

   // Check that idle permits motion once idle_lock is cleared
   task automatic test_idle_without_arm();
      write_idle_lock(1'b0);
      send_op(OP_DISARM, 1'b0);
      send_op(OP_MOTION, 1'b0);
      send_op(OP_ESTOP, 1'b1);
      send_op(OP_CLR_ESTOP, 1'b0);
      write_idle_lock(1'b1);
      send_op(OP_MOTION, 1'b0);
   endtask

   // Random events under one idle_lock setting
   task automatic test_random_events(input int n_items, input logic arm_setting,
                                     input bit no_stalls);
      req_type ev;
      write_idle_lock(arm_setting);
      quiet_stretch = no_stalls;
      for (int i = 0; i < n_items; i++) begin
         if ($urandom_range(99) < 8) ev.opcode = opcode_type'(4'($urandom_range(15, 12)));
         else ev.opcode = opcode_type'(4'($urandom_range(11, 0)));
         ev.twist_nonzero = 1'($urandom_range(1));
         send_event(ev);
      end
      wait_for_results();
      quiet_stretch = 1'b0;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_mode_commands();
      test_intent_and_unknown();
      test_idle_without_arm();
      test_random_events(300, 1'b1, 1'b0);
      test_random_events(300, 1'b0, 1'b0);
      test_random_events(300, 1'b0, 1'b1);
      test_random_events(300, 1'b1, 1'b0);
      wait_for_results();
      repeat (4) @(negedge clock);
      if (mismatch_count == 0 && expected_status_q.size() == 0) begin
         $display("[vehicle_operational_mode_fsm_core] OK");
      end else begin
         $display("[vehicle_operational_mode_fsm_core] ERROR");
      end
      $finish;
   end

endmodule
